[design/disc_pair_collision_response_unit_defines.svh]
// Assertion macros shared by the checker of the disc pair collision unit.
// Needs a clock named i_clk and a synchronous active-low reset named i_rst_n in scope.
`ifndef DISC_PAIR_COLLISION_RESPONSE_UNIT_DEFINES_SVH
`define DISC_PAIR_COLLISION_RESPONSE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define DPCR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dpcr assertion failed");

// Next-cycle implication, disabled in reset.
`define DPCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dpcr assertion failed");

`endif

[design/dpcr_pkg.sv]
// Shared types, constants and helpers of the disc pair collision unit.
// No dependencies.
package dpcr_pkg;

    localparam logic [12:0] RADIUS_RESET = 13'd410;
    localparam logic [33:0] MIN_DIST2    = 34'd17;
    localparam int unsigned QBITS        = 22;
    // stage registers: 6 front stages, one per quotient bit, one output stage
    localparam int unsigned NSTAGE       = 6 + QBITS + 1;

    typedef struct packed {
        logic signed [19:0] avx;
        logic signed [19:0] avz;
        logic signed [19:0] bvx;
        logic signed [19:0] bvz;
        logic               vis;
        logic               hit;
        logic signed [16:0] dx;
        logic signed [16:0] dz;
        logic signed [20:0] dvx;
        logic signed [20:0] dvz;
        logic        [33:0] dxx;
        logic        [33:0] dzz;
        logic signed [37:0] px;
        logic signed [37:0] pz;
        logic        [33:0] d2;
        logic signed [38:0] dot;
        logic        [13:0] magx;
        logic        [13:0] magz;
        logic        [35:0] dotm;
        logic        [49:0] numx;
        logic        [49:0] numz;
        logic        [50:0] remx;
        logic        [50:0] remz;
        logic        [28:0] den;
        logic        [21:0] qx;
        logic        [21:0] qz;
    } t_item;

    function automatic logic signed [19:0] sat_vel(input logic signed [23:0] v);
        logic signed [19:0] r;
        if (v > 24'sd524287) begin
            r = 20'sd524287;
        end else if (v < -24'sd524288) begin
            r = -20'sd524288;
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

endpackage

[design/dpcr_div_step.sv]
// One restoring division step for the x and z exchange quotients.
// Depends on dpcr_pkg for the item type.
module dpcr_div_step #(
    parameter int unsigned BIT = 0
) (
    input  dpcr_pkg::t_item i_item,
    output dpcr_pkg::t_item o_item
);

    logic [50:0] w_sub;

    assign w_sub = 51'(i_item.den) << BIT;

    always_comb begin
        o_item = i_item;
        if (i_item.remx >= w_sub) begin
            o_item.remx    = i_item.remx - w_sub;
            o_item.qx[BIT] = 1'b1;
        end
        if (i_item.remz >= w_sub) begin
            o_item.remz    = i_item.remz - w_sub;
            o_item.qz[BIT] = 1'b1;
        end
    end

endmodule

[design/disc_pair_collision_response_unit.sv]
// Equal-mass elastic collision of two discs: a pipeline of 29 register stages.
// One request enters per cycle while o_ready is high; the stages are six front stages
// (difference, products, sums, test, numerator product, rounding prep), one restoring
// divider step per quotient bit (22) and the saturating output register. Bubbles
// collapse under back-pressure.
module disc_pair_collision_response_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [12:0] i_cfg_disc_radius,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_a_x,
    input  logic signed [15:0] i_a_z,
    input  logic signed [19:0] i_a_vx,
    input  logic signed [19:0] i_a_vz,
    input  logic               i_a_visible,
    input  logic signed [15:0] i_b_x,
    input  logic signed [15:0] i_b_z,
    input  logic signed [19:0] i_b_vx,
    input  logic signed [19:0] i_b_vz,
    input  logic               i_b_visible,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [19:0] o_new_a_vx,
    output logic signed [19:0] o_new_a_vz,
    output logic signed [19:0] o_new_b_vx,
    output logic signed [19:0] o_new_b_vz,
    output logic               o_collided
);

    localparam int unsigned N = dpcr_pkg::NSTAGE;
    localparam int unsigned Q = dpcr_pkg::QBITS;

    logic [12:0]     r_radius;
    logic [27:0]     r_lim;
    logic [13:0]     w_two_r;
    dpcr_pkg::t_item r_pipe [N];
    dpcr_pkg::t_item n_pipe [N];
    logic [N-1:0]    r_vld;
    logic [N:0]      w_en;

    assign o_cfg_ready = 1'b1;
    assign w_two_r     = {r_radius, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= dpcr_pkg::RADIUS_RESET;
        end else if (i_cfg_valid) begin
            r_radius <= i_cfg_disc_radius;
        end
        r_lim <= w_two_r * w_two_r;
    end

    // advance a stage when it is empty or its successor advances
    always_comb begin
        w_en[N] = i_ready;
        for (int k = N - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end
    assign o_ready = w_en[0];

    always_comb begin
        logic signed [16:0] t_ax;
        logic signed [16:0] t_az;
        n_pipe[0]     = r_pipe[0];
        n_pipe[0].avx = i_a_vx;
        n_pipe[0].avz = i_a_vz;
        n_pipe[0].bvx = i_b_vx;
        n_pipe[0].bvz = i_b_vz;
        n_pipe[0].vis = i_a_visible & i_b_visible;
        n_pipe[0].dx  = 17'(i_b_x) - 17'(i_a_x);
        n_pipe[0].dz  = 17'(i_b_z) - 17'(i_a_z);
        n_pipe[0].dvx = 21'(i_a_vx) - 21'(i_b_vx);
        n_pipe[0].dvz = 21'(i_a_vz) - 21'(i_b_vz);

        n_pipe[1]     = r_pipe[0];
        n_pipe[1].dxx = 34'(r_pipe[0].dx * r_pipe[0].dx);
        n_pipe[1].dzz = 34'(r_pipe[0].dz * r_pipe[0].dz);
        n_pipe[1].px  = 38'(r_pipe[0].dvx) * 38'(r_pipe[0].dx);
        n_pipe[1].pz  = 38'(r_pipe[0].dvz) * 38'(r_pipe[0].dz);

        n_pipe[2]     = r_pipe[1];
        n_pipe[2].d2  = r_pipe[1].dxx + r_pipe[1].dzz;
        n_pipe[2].dot = 39'(r_pipe[1].px) + 39'(r_pipe[1].pz);

        // both visible, in range, not coincident, approaching; dot of zero still counts
        t_ax           = r_pipe[2].dx[16] ? -r_pipe[2].dx : r_pipe[2].dx;
        t_az           = r_pipe[2].dz[16] ? -r_pipe[2].dz : r_pipe[2].dz;
        n_pipe[3]      = r_pipe[2];
        n_pipe[3].hit  = r_pipe[2].vis && (r_pipe[2].d2 <= 34'(r_lim))
                         && (r_pipe[2].d2 >= dpcr_pkg::MIN_DIST2) && !r_pipe[2].dot[38];
        n_pipe[3].magx = t_ax[13:0];
        n_pipe[3].magz = t_az[13:0];
        n_pipe[3].dotm = r_pipe[2].dot[35:0];

        n_pipe[4]      = r_pipe[3];
        n_pipe[4].numx = 50'(r_pipe[3].dotm) * 50'(r_pipe[3].magx);
        n_pipe[4].numz = 50'(r_pipe[3].dotm) * 50'(r_pipe[3].magz);

        // round half away: (2*num + d2) / (2*d2)
        n_pipe[5]      = r_pipe[4];
        n_pipe[5].remx = {r_pipe[4].numx, 1'b0} + 51'(r_pipe[4].d2[27:0]);
        n_pipe[5].remz = {r_pipe[4].numz, 1'b0} + 51'(r_pipe[4].d2[27:0]);
        n_pipe[5].den  = {r_pipe[4].d2[27:0], 1'b0};
        n_pipe[5].qx   = '0;
        n_pipe[5].qz   = '0;
    end

    for (genvar j = 0; j < Q; j++) begin : g_div
        dpcr_div_step #(
            .BIT(Q - 1 - j)
        ) u_step (
            .i_item(r_pipe[5+j]),
            .o_item(n_pipe[6+j])
        );
    end

    always_comb begin
        logic signed [22:0] t_ex;
        logic signed [22:0] t_ez;
        t_ex = r_pipe[N-2].dx[16] ? -$signed({1'b0, r_pipe[N-2].qx})
                                  :  $signed({1'b0, r_pipe[N-2].qx});
        t_ez = r_pipe[N-2].dz[16] ? -$signed({1'b0, r_pipe[N-2].qz})
                                  :  $signed({1'b0, r_pipe[N-2].qz});
        n_pipe[N-1] = r_pipe[N-2];
        if (r_pipe[N-2].hit) begin
            n_pipe[N-1].avx = dpcr_pkg::sat_vel(24'(r_pipe[N-2].avx) - 24'(t_ex));
            n_pipe[N-1].avz = dpcr_pkg::sat_vel(24'(r_pipe[N-2].avz) - 24'(t_ez));
            n_pipe[N-1].bvx = dpcr_pkg::sat_vel(24'(r_pipe[N-2].bvx) + 24'(t_ex));
            n_pipe[N-1].bvz = dpcr_pkg::sat_vel(24'(r_pipe[N-2].bvz) + 24'(t_ez));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            if (w_en[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < N; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_valid    = r_vld[N-1];
    assign o_new_a_vx = r_pipe[N-1].avx;
    assign o_new_a_vz = r_pipe[N-1].avz;
    assign o_new_b_vx = r_pipe[N-1].bvx;
    assign o_new_b_vz = r_pipe[N-1].bvz;
    assign o_collided = r_pipe[N-1].hit;

endmodule

[design/dpcr_checker.sv]
// Port-level checks on the disc pair collision unit, bound to its top level.
// Uses the assertion macros of disc_pair_collision_response_unit_defines.svh.
`include "disc_pair_collision_response_unit_defines.svh"

module dpcr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [19:0] o_new_a_vx,
    input logic signed [19:0] o_new_a_vz,
    input logic signed [19:0] o_new_b_vx,
    input logic signed [19:0] o_new_b_vz,
    input logic               o_collided
);

    logic [80:0] w_out;

    assign w_out = {o_new_a_vx, o_new_a_vz, o_new_b_vx, o_new_b_vz, o_collided};

    // hold a stalled result
    `DPCR_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid)
    `DPCR_ASSERT_NEXT(a_out_stable, o_valid && !i_ready, $stable(w_out))
    // an empty output stage means the whole pipe can advance
    `DPCR_ASSERT_NOW(a_empty_ready, !o_valid, o_ready)
    `DPCR_ASSERT_NOW(a_cfg_ready, i_cfg_valid, o_cfg_ready)

endmodule

bind disc_pair_collision_response_unit dpcr_checker u_dpcr_checker (.*);
